// File: src/ecdsa_der_pkg.sv
// ----------------------------------------------------------------------------
// ecdsa_der_pkg
// Shared types and constants of the ECDSA signature DER encoder: byte
// source selects, controller commands and datapath status.
// ----------------------------------------------------------------------------
package ecdsa_der_pkg;

   localparam int BYTE_W  = 8;
   localparam int SIZE_W  = 6;
   localparam int TOTAL_W = 7;
   localparam int LEN_W   = 8;

   localparam logic [BYTE_W-1:0] SEQ_TAG    = 8'h30;
   localparam logic [BYTE_W-1:0] INT_TAG    = 8'h02;
   localparam logic [BYTE_W-1:0] LONG_LEN1  = 8'h81;
   localparam logic [BYTE_W-1:0] LONG_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;

   localparam logic [SIZE_W-1:0] INT_BYTES_RESET = 6'd32;

   typedef enum logic [3:0] {
      SEL_SEQ_TAG,
      SEL_LONG,
      SEL_SEQ_LEN,
      SEL_INT_TAG,
      SEL_R_LEN,
      SEL_PAD,
      SEL_R_BYTE,
      SEL_S_LEN,
      SEL_S_BYTE
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    emit;
      logic    last;
      logic    rd_en;
      logic    rd_first;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic long_form;
      logic r_pad;
      logic s_pad;
      logic last_item;
      logic s_final;
      logic out_free;
   } status_type;

endpackage

// File: src/ecdsa_der_ctrl.sv
// ----------------------------------------------------------------------------
// ecdsa_der_ctrl
// Sequencer that walks the header, r and s bytes of one input transfer and
// tells the datapath which byte to place in the output register.
// ----------------------------------------------------------------------------
module ecdsa_der_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ecdsa_der_pkg::status_type status,
   output ecdsa_der_pkg::cmd_type    cmd
);
   import ecdsa_der_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEQ_TAG,
      ST_SEQ_LONG,
      ST_SEQ_LEN,
      ST_R_TAG,
      ST_R_LEN,
      ST_R_PAD,
      ST_R_BYTE,
      ST_S_TAG,
      ST_S_LEN,
      ST_S_PAD,
      ST_S_BYTE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.sel      = SEL_SEQ_TAG;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.first ? ST_SEQ_TAG : ST_R_BYTE;
            end
         end
         ST_SEQ_TAG: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_SEQ_TAG;
               state_in = status.long_form ? ST_SEQ_LONG : ST_SEQ_LEN;
            end
         end
         ST_SEQ_LONG: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_LONG;
               state_in = ST_SEQ_LEN;
            end
         end
         ST_SEQ_LEN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_SEQ_LEN;
               state_in = ST_R_TAG;
            end
         end
         ST_R_TAG: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_INT_TAG;
               state_in = ST_R_LEN;
            end
         end
         ST_R_LEN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_R_LEN;
               state_in = status.r_pad ? ST_R_PAD : ST_R_BYTE;
            end
         end
         ST_R_PAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_PAD;
               state_in = ST_R_BYTE;
            end
         end
         ST_R_BYTE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_R_BYTE;
               state_in = status.last_item ? ST_S_TAG : ST_IDLE;
            end
         end
         ST_S_TAG: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_INT_TAG;
               cmd.rd_en    = 1'b1;
               cmd.rd_first = 1'b1;
               state_in     = ST_S_LEN;
            end
         end
         ST_S_LEN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_S_LEN;
               state_in = status.s_pad ? ST_S_PAD : ST_S_BYTE;
            end
         end
         ST_S_PAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_PAD;
               state_in = ST_S_BYTE;
            end
         end
         ST_S_BYTE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_S_BYTE;
               if (status.s_final) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = stall_ff;

endmodule

// File: src/ecdsa_der_dpath.sv
// ----------------------------------------------------------------------------
// ecdsa_der_dpath
// Size register, item position, length computation, s byte store and the
// output register of the DER encoder.
// ----------------------------------------------------------------------------
module ecdsa_der_dpath #(
   parameter int MAX_INT_BYTES = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ecdsa_der_pkg::SIZE_W-1:0]      csr_wr_data,
   input  logic [ecdsa_der_pkg::BYTE_W-1:0]      req_r_byte,
   input  logic [ecdsa_der_pkg::BYTE_W-1:0]      req_s_byte,
   input  ecdsa_der_pkg::cmd_type                cmd,
   output ecdsa_der_pkg::status_type             status,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [ecdsa_der_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                                  rsp_last,
   output logic [ecdsa_der_pkg::TOTAL_W-1:0]     rsp_total_length
);
   import ecdsa_der_pkg::*;

   localparam int AW = (MAX_INT_BYTES > 1) ? $clog2(MAX_INT_BYTES) : 1;
   localparam int CW = $clog2(MAX_INT_BYTES + 1);
   localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_INT_BYTES);

   logic [SIZE_W-1:0]  int_bytes_ff;
   logic [SIZE_W-1:0]  n_eff;
   logic [CW-1:0]      pos_ff;
   logic [SIZE_W:0]    pos_next;
   logic               last_now;
   logic [LEN_W-1:0]   seq_now;
   logic [LEN_W-1:0]   total_now;

   logic [LEN_W-1:0]   seq_ff;
   logic [LEN_W-1:0]   total_ff;
   logic               r_pad_ff;
   logic               s_pad_ff;
   logic               last_item_ff;
   logic [BYTE_W-1:0]  r_ff;

   logic [BYTE_W-1:0]  s_mem [MAX_INT_BYTES];
   logic [BYTE_W-1:0]  s_q_ff;
   logic [AW-1:0]      ptr_ff;
   logic [AW-1:0]      rd_addr;

   logic [BYTE_W-1:0]  byte_sel;
   logic               valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               last_ff;
   logic [TOTAL_W-1:0] total_out_ff;

   // effective size, clamped to 1..MAX_INT_BYTES
   always_comb begin
      if (int_bytes_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (int_bytes_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = int_bytes_ff;
      end
   end

   assign pos_next  = (SIZE_W + 1)'(pos_ff) + (SIZE_W + 1)'(1);
   assign last_now  = (pos_next >= {1'b0, n_eff});
   assign seq_now   = LEN_W'({n_eff, 1'b0}) + LEN_W'(req_r_byte[BYTE_W-1])
                    + LEN_W'(req_s_byte[BYTE_W-1]) + LEN_W'(4);
   assign total_now = (seq_now >= LONG_LIMIT) ? seq_now + LEN_W'(3)
                                              : seq_now + LEN_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         int_bytes_ff <= INT_BYTES_RESET;
         pos_ff       <= '0;
         s_pad_ff     <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            int_bytes_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            pos_ff <= last_now ? '0 : CW'(pos_next);
            if (pos_ff == '0) begin
               s_pad_ff <= req_s_byte[BYTE_W-1];
               total_ff <= total_now;
            end
         end
      end
   end

   // per-item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff         <= req_r_byte;
         last_item_ff <= last_now;
         if (pos_ff == '0) begin
            seq_ff   <= seq_now;
            r_pad_ff <= req_r_byte[BYTE_W-1];
         end
      end
   end

   // s byte store, registered read
   assign rd_addr = cmd.rd_first ? '0 : ptr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_mem[pos_ff[AW-1:0]] <= req_s_byte;
      end
      if (cmd.rd_en) begin
         s_q_ff <= s_mem[rd_addr];
         ptr_ff <= rd_addr;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_SEQ_TAG: byte_sel = SEQ_TAG;
         SEL_LONG:    byte_sel = LONG_LEN1;
         SEL_SEQ_LEN: byte_sel = seq_ff;
         SEL_INT_TAG: byte_sel = INT_TAG;
         SEL_R_LEN:   byte_sel = BYTE_W'(n_eff) + BYTE_W'(r_pad_ff);
         SEL_PAD:     byte_sel = PAD_BYTE;
         SEL_R_BYTE:  byte_sel = r_ff;
         SEL_S_LEN:   byte_sel = BYTE_W'(n_eff) + BYTE_W'(s_pad_ff);
         SEL_S_BYTE:  byte_sel = s_q_ff;
         default:     byte_sel = PAD_BYTE;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff  <= byte_sel;
         last_ff      <= cmd.last;
         total_out_ff <= total_ff[TOTAL_W-1:0];
      end
   end

   assign status.first     = (pos_ff == '0);
   assign status.long_form = (seq_ff >= LONG_LIMIT);
   assign status.r_pad     = r_pad_ff;
   assign status.s_pad     = s_pad_ff;
   assign status.last_item = last_item_ff;
   assign status.s_final   = ((SIZE_W + 1)'(ptr_ff) + (SIZE_W + 1)'(1)) == {1'b0, n_eff};
   assign status.out_free  = !valid_ff || !rsp_stall;

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last         = last_ff;
   assign rsp_total_length = total_out_ff;

endmodule

// File: src/ecdsa_signature_der_encoder.sv
// ----------------------------------------------------------------------------
// ecdsa_signature_der_encoder
// Wraps r and s, fed one byte pair per transfer, most significant first, in
// a DER SEQUENCE of two INTEGERs, one encoded byte per result transfer.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_r_byte req_s_byte | in
//   rsp     | rsp_valid rsp_stall rsp_out_byte          | out
//           | rsp_last rsp_total_length                 |
//   csr     | csr_wr_en csr_wr_data (int_bytes)         | in
//
// a transfer is taken while idle, then its bytes leave one per cycle while
// rsp_stall is low, through the single output byte register; no new
// transfer is taken until the last of them has been placed in it.
// synchronous active-high reset, no clearing pass; s store needs none.
// rsp_stall holds the current byte and the sequencer; req_stall is high
// while a transfer is being expanded.
// ----------------------------------------------------------------------------
module ecdsa_signature_der_encoder #(
   parameter int MAX_INT_BYTES = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ecdsa_der_pkg::BYTE_W-1:0]      req_r_byte,
   input  logic [ecdsa_der_pkg::BYTE_W-1:0]      req_s_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ecdsa_der_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                                  rsp_last,
   output logic [ecdsa_der_pkg::TOTAL_W-1:0]     rsp_total_length,
   input  logic                                  csr_wr_en,
   input  logic [ecdsa_der_pkg::SIZE_W-1:0]      csr_wr_data
);
   import ecdsa_der_pkg::*;

   cmd_type    cmd;
   status_type status;

   ecdsa_der_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ecdsa_der_dpath #(
      .MAX_INT_BYTES (MAX_INT_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_r_byte       (req_r_byte),
      .req_s_byte       (req_s_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_total_length (rsp_total_length)
   );

endmodule

// File: src/ecdsa_der_checker.sv
// ----------------------------------------------------------------------------
// ecdsa_der_checker
// Port-level checks of the DER encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ecdsa_der_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [ecdsa_der_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic                                  rsp_last,
   input logic [ecdsa_der_pkg::TOTAL_W-1:0]     rsp_total_length
);
   import ecdsa_der_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("result changed while stalled");

   // one signature keeps one length
   a_total_steady: assert property (@(posedge clock) disable iff (reset)
      ((rsp_valid && !rsp_stall && !rsp_last) ##1 rsp_valid)
      |-> (rsp_total_length == $past(rsp_total_length)))
      else $error("total length changed inside a signature");

   // a new signature opens with the sequence tag
   a_seq_start: assert property (@(posedge clock) disable iff (reset)
      ((rsp_valid && !rsp_stall && rsp_last) ##1 rsp_valid) |-> (rsp_out_byte == SEQ_TAG))
      else $error("signature does not start with sequence tag");

   // shortest encoding is eight bytes
   a_total_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_length >= TOTAL_W'(8)))
      else $error("total length too small");

endmodule

bind ecdsa_signature_der_encoder ecdsa_der_checker u_ecdsa_der_checker (.*);
